@@ src/wsa_pkg.sv @@
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants for the window slot assigner.
// ----------------------------------------------------------------------------
package wsa_pkg;

    localparam int SLOT_W = 7;
    localparam int IDX_W  = 6;

    localparam logic AXIS_COL = 1'b0;
    localparam logic AXIS_ROW = 1'b1;

    // One input word: a window's column and row ranges.
    typedef struct packed {
        logic [SLOT_W-1:0] col_low;
        logic [SLOT_W-1:0] col_high;
        logic [SLOT_W-1:0] row_low;
        logic [SLOT_W-1:0] row_high;
        logic              last;
    } t_in;

    // One result word.
    typedef struct packed {
        logic [IDX_W-1:0]  window_index;
        logic [SLOT_W-1:0] col_slot;
        logic [SLOT_W-1:0] row_slot;
        logic              fail;
        logic              end_of_set;
    } t_out;

    // Stored bounds of one window.
    typedef struct packed {
        logic [SLOT_W-1:0] col_lo;
        logic [SLOT_W-1:0] col_hi;
        logic [SLOT_W-1:0] row_lo;
        logic [SLOT_W-1:0] row_hi;
    } t_bounds;

    // Result write from the assignment unit.
    typedef struct packed {
        logic              en;
        logic              axis;
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic              fail;
    } t_res_wr;

endpackage

@@ src/wsa_assign_unit.sv @@
// ----------------------------------------------------------------------------
// wsa_assign_unit
// Holds the window bounds and assigns slots one axis at a time: a scan picks
// the next window by (upper, lower, load order), then a probe walks the
// free map upward from its lower bound.
// ----------------------------------------------------------------------------
module wsa_assign_unit #(
    parameter int MAX_WINDOWS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(MAX_WINDOWS)-1:0]   i_wr_addr,
    input  wsa_pkg::t_bounds                 i_wr_data,
    input  logic                             i_start,
    input  logic [$clog2(MAX_WINDOWS+1)-1:0] i_n,
    output wsa_pkg::t_res_wr                 o_res,
    output logic                             o_done
);

    localparam int IW = $clog2(MAX_WINDOWS);
    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam int SW = wsa_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_INIT   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_SEARCH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    wsa_pkg::t_bounds r_mem [MAX_WINDOWS];
    wsa_pkg::t_bounds r_rdat;

    logic [CW-1:0]          r_n, n_n;
    logic                   r_axis, n_axis;
    logic [CW-1:0]          r_pick, n_pick;
    logic [CW-1:0]          r_j, n_j;
    logic                   r_rv;
    logic [IW-1:0]          r_ridx;
    logic                   r_best_v, n_best_v;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    logic [SW-1:0]          r_best_lo, n_best_lo;
    logic [SW-1:0]          r_best_hi, n_best_hi;
    logic [SW-1:0]          r_s, n_s;
    logic [MAX_WINDOWS-1:0] r_free, n_free;
    logic [MAX_WINDOWS-1:0] r_done, n_done;
    logic                   r_fin, n_fin;

    logic [SW-1:0] cand_lo, cand_hi;
    logic [SW-1:0] s_m1;
    logic [SW-1:0] n_ext;
    logic          cand_better;

    wsa_pkg::t_res_wr res;

    // Bounds memory: written while loading, read once per scan cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdat <= r_mem[r_j[IW-1:0]];
        r_ridx <= r_j[IW-1:0];
    end

    // Candidate bounds of the axis being assigned.
    assign cand_lo = (r_axis == wsa_pkg::AXIS_COL) ? r_rdat.col_lo : r_rdat.row_lo;
    assign cand_hi = (r_axis == wsa_pkg::AXIS_COL) ? r_rdat.col_hi : r_rdat.row_hi;
    assign cand_better = !r_best_v || (cand_hi < r_best_hi) ||
                         ((cand_hi == r_best_hi) && (cand_lo < r_best_lo));
    assign s_m1  = r_s - SW'(1);
    assign n_ext = SW'(r_n);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_axis     = r_axis;
        n_pick     = r_pick;
        n_j        = r_j;
        n_best_v   = r_best_v;
        n_best_idx = r_best_idx;
        n_best_lo  = r_best_lo;
        n_best_hi  = r_best_hi;
        n_s        = r_s;
        n_free     = r_free;
        n_done     = r_done;
        n_fin      = 1'b0;
        res        = '0;
        res.axis   = r_axis;
        res.idx    = wsa_pkg::IDX_W'(r_best_idx);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_axis  = wsa_pkg::AXIS_COL;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                for (int b = 0; b < MAX_WINDOWS; b++) begin
                    n_free[b] = (b < int'(r_n));
                end
                n_done   = '0;
                n_pick   = '0;
                n_j      = '0;
                n_best_v = 1'b0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (r_j < r_n) begin
                    n_j = r_j + CW'(1);
                end
                if (r_rv && !r_done[r_ridx] && cand_better) begin
                    n_best_v   = 1'b1;
                    n_best_idx = r_ridx;
                    n_best_lo  = cand_lo;
                    n_best_hi  = cand_hi;
                end
                if ((r_j == r_n) && !r_rv) begin
                    n_s     = (r_best_lo == '0) ? SW'(1) : r_best_lo;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_s > n_ext) begin
                    // No free slot at or above the lower bound.
                    res.en   = 1'b1;
                    res.slot = '0;
                    res.fail = 1'b1;
                end else if (r_free[s_m1[IW-1:0]]) begin
                    res.en   = 1'b1;
                    res.slot = r_s;
                    res.fail = (r_s > r_best_hi);
                    n_free[s_m1[IW-1:0]] = 1'b0;
                end else begin
                    n_s = r_s + SW'(1);
                end
                if (res.en) begin
                    n_done[r_best_idx] = 1'b1;
                    n_pick   = r_pick + CW'(1);
                    n_j      = '0;
                    n_best_v = 1'b0;
                    if (n_pick == r_n) begin
                        if (r_axis == wsa_pkg::AXIS_COL) begin
                            n_axis  = wsa_pkg::AXIS_ROW;
                            n_state = S_INIT;
                        end else begin
                            n_fin   = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= (r_state == S_SCAN) && (r_j < r_n);
            r_fin   <= n_fin;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_axis     <= n_axis;
        r_pick     <= n_pick;
        r_j        <= n_j;
        r_best_v   <= n_best_v;
        r_best_idx <= n_best_idx;
        r_best_lo  <= n_best_lo;
        r_best_hi  <= n_best_hi;
        r_s        <= n_s;
        r_free     <= n_free;
        r_done     <= n_done;
    end

    assign o_res  = res;
    assign o_done = r_fin;

    // A result is written only while probing the free map.
    a_res_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.en |-> (r_state == S_SEARCH))
        else $error("result written outside search");

    // The probe slot is never zero while it is within the set size.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) && (r_s <= n_ext) |-> (r_s != '0))
        else $error("probe slot zero");

    // Picks never exceed the set size.
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) || (r_state == S_SEARCH) |-> (r_pick < r_n))
        else $error("pick count past set size");

endmodule

@@ src/window_slot_assigner_core.sv @@
// ----------------------------------------------------------------------------
// window_slot_assigner_core
// Collects a set of windows and assigns each a column and a row slot.
// ----------------------------------------------------------------------------
// Windows load one word per cycle. The word with last set starts assignment,
// during which the input is stalled: each axis makes n picks, and each pick
// scans the bounds memory (one read port) and then probes the free map one
// slot at a time upward from the lower bound. Results then leave in load
// order, each word read from the result memories (T_RD) and then offered
// (T_WAIT) until taken, after which a new set may load.
module window_slot_assigner_core #(
    parameter int MAX_WINDOWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  wsa_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output wsa_pkg::t_out o_data
);

    localparam int IW = $clog2(MAX_WINDOWS);
    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam int SW = wsa_pkg::SLOT_W;

    typedef enum logic [3:0] {
        T_LOAD   = 4'b0001,
        T_ASSIGN = 4'b0010,
        T_RD     = 4'b0100,
        T_WAIT   = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_k, n_k;

    logic [SW:0] r_col_mem [MAX_WINDOWS];
    logic [SW:0] r_row_mem [MAX_WINDOWS];
    logic [SW:0] r_col_rd, r_row_rd;

    logic             accept, wr_en, start, asg_done;
    logic [CW-1:0]    n_set;
    wsa_pkg::t_bounds wr_data;
    wsa_pkg::t_res_wr res;

    assign accept = i_valid && !o_stall && (r_state == T_LOAD);
    assign wr_en  = accept && (r_cnt < CW'(MAX_WINDOWS));
    assign start  = accept && i_data.last;
    assign n_set  = wr_en ? (r_cnt + CW'(1)) : r_cnt;

    assign wr_data.col_lo = i_data.col_low;
    assign wr_data.col_hi = i_data.col_high;
    assign wr_data.row_lo = i_data.row_low;
    assign wr_data.row_hi = i_data.row_high;

    wsa_assign_unit #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_assign (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[IW-1:0]),
        .i_wr_data (wr_data),
        .i_start   (start),
        .i_n       (n_set),
        .o_res     (res),
        .o_done    (asg_done)
    );

    // Result memories, one per axis; read in load order when emitting.
    always_ff @(posedge i_clk) begin
        if (res.en && (res.axis == wsa_pkg::AXIS_COL)) begin
            r_col_mem[res.idx[IW-1:0]] <= {res.slot, res.fail};
        end
        if (res.en && (res.axis == wsa_pkg::AXIS_ROW)) begin
            r_row_mem[res.idx[IW-1:0]] <= {res.slot, res.fail};
        end
        r_col_rd <= r_col_mem[r_k[IW-1:0]];
        r_row_rd <= r_row_mem[r_k[IW-1:0]];
    end

    // Load, assign and emit sequencing.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_k     = r_k;
        case (r_state)
            T_LOAD: begin
                if (accept) begin
                    n_cnt = n_set;
                    if (i_data.last) begin
                        n_n     = n_set;
                        n_state = T_ASSIGN;
                    end
                end
            end
            T_ASSIGN: begin
                if (asg_done) begin
                    n_k     = '0;
                    n_state = T_RD;
                end
            end
            T_RD: begin
                n_state = T_WAIT;
            end
            T_WAIT: begin
                if (!i_stall) begin
                    if (r_k == (r_n - CW'(1))) begin
                        n_cnt   = '0;
                        n_state = T_LOAD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = T_RD;
                    end
                end
            end
            default: begin
                n_state = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_k <= n_k;
    end

    // Output word comes straight from the registered memory reads.
    assign o_stall = (r_state != T_LOAD);
    assign o_valid = (r_state == T_WAIT);
    assign o_data.window_index = wsa_pkg::IDX_W'(r_k);
    assign o_data.col_slot     = r_col_rd[SW:1];
    assign o_data.row_slot     = r_row_rd[SW:1];
    assign o_data.fail         = r_col_rd[0] | r_row_rd[0];
    assign o_data.end_of_set   = (r_k == (r_n - CW'(1)));

    // Results are written only while assignment runs.
    a_res_when_assign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.en |-> (r_state == T_ASSIGN))
        else $error("result write outside assignment");

    // The window count never passes the store depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_WINDOWS))
        else $error("window count overflow");

    // Emission stays inside the set.
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WAIT) |-> (r_k < r_n))
        else $error("emit index past set");

endmodule

@@ dv/window_slot_assigner_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_slot_assigner_core_tb
// Loads window sets into the slot assigner and checks every (column, row)
// result word against a greedy per-axis slot assignment computed here.
// ----------------------------------------------------------------------------
module window_slot_assigner_core_tb;

    localparam int NWIN       = 64;
    localparam int IDLE_LIMIT = 200000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    wsa_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    wsa_pkg::t_out o_data;

    // Held windows of the set being loaded.
    wsa_pkg::t_bounds held_bounds[$];
    // Result words still to come, oldest first.
    wsa_pkg::t_out    pending_slots[$];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    window_slot_assigner_core #(.MAX_WINDOWS(NWIN)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Greedy assignment of one axis; fills slots and ORs fail flags.
    task automatic assign_axis(input bit use_row, input int n,
                               ref logic [6:0] slots[NWIN], ref bit fails[NWIN]);
        int order[NWIN];
        logic [6:0] lo[NWIN];
        logic [6:0] hi[NWIN];
        bit [63:0] free_slots;
        int k, p, cur, w, s, start, found;
        for (k = 0; k < n; k++) begin
            lo[k] = use_row ? held_bounds[k].row_lo : held_bounds[k].col_lo;
            hi[k] = use_row ? held_bounds[k].row_hi : held_bounds[k].col_hi;
            order[k] = k;
        end
        // Stable insertion sort by upper bound, then lower bound.
        for (k = 1; k < n; k++) begin
            cur = order[k];
            p = k;
            while (p > 0 && (hi[order[p-1]] > hi[cur] ||
                   (hi[order[p-1]] == hi[cur] && lo[order[p-1]] > lo[cur]))) begin
                order[p] = order[p-1];
                p--;
            end
            order[p] = cur;
        end
        free_slots = '0;
        for (s = 0; s < n; s++) free_slots[s] = 1'b1;
        for (k = 0; k < n; k++) begin
            w = order[k];
            start = (lo[w] == 0) ? 1 : lo[w];
            found = 0;
            for (s = start; s <= n; s++) begin
                if (free_slots[s-1]) begin
                    found = s;
                    break;
                end
            end
            if (found == 0) begin
                fails[w] = 1'b1;
            end else begin
                free_slots[found-1] = 1'b0;
                if (found > hi[w]) fails[w] = 1'b1;
            end
            slots[w] = found[6:0];
        end
    endtask

    // Update the window store with one accepted word; on last, queue results.
    task automatic predict_window(input wsa_pkg::t_in word);
        logic [6:0] col_slots[NWIN];
        logic [6:0] row_slots[NWIN];
        bit fails[NWIN];
        wsa_pkg::t_out res;
        int n;
        if (held_bounds.size() < NWIN)
            held_bounds.push_back({word.col_low, word.col_high,
                                   word.row_low, word.row_high});
        if (word.last) begin
            n = held_bounds.size();
            for (int k = 0; k < NWIN; k++) fails[k] = 1'b0;
            assign_axis(1'b0, n, col_slots, fails);
            assign_axis(1'b1, n, row_slots, fails);
            for (int k = 0; k < n; k++) begin
                res.window_index = k[5:0];
                res.col_slot     = col_slots[k];
                res.row_slot     = row_slots[k];
                res.fail         = fails[k];
                res.end_of_set   = (k == n - 1);
                pending_slots.push_back(res);
            end
            held_bounds.delete();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Send one word, idling first at the sender's rate. Valid stays high
    // after the accepting edge until the next word or an idle cycle follows.
    task automatic send_window(input wsa_pkg::t_in word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_window(word);
    endtask

    function automatic wsa_pkg::t_in make_window(int n, bit last);
        wsa_pkg::t_in word;
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            // Well-formed: ranges within 1..n.
            word.col_low  = 7'($urandom_range(n, 1));
            word.col_high = 7'($urandom_range(n, word.col_low));
            word.row_low  = 7'($urandom_range(n, 1));
            word.row_high = 7'($urandom_range(n, word.row_low));
        end else begin
            word.col_low  = 7'($urandom_range(127));
            word.col_high = 7'($urandom_range(127));
            word.row_low  = 7'($urandom_range(127));
            word.row_high = 7'($urandom_range(127));
        end
        word.last = last;
        return word;
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++) send_window(make_window(n, k == n - 1));
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_slots.size() != 0) @(posedge i_clk);
    endtask

    // Result checker with random receiver stalls.
    always @(posedge i_clk) begin
        wsa_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_slots.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = pending_slots.pop_front();
                if (o_data.window_index !== want.window_index)
                    report_mismatch($sformatf("window_index %0d want %0d",
                        o_data.window_index, want.window_index));
                if (o_data.col_slot !== want.col_slot)
                    report_mismatch($sformatf("col_slot %0d want %0d (win %0d)",
                        o_data.col_slot, want.col_slot, want.window_index));
                if (o_data.row_slot !== want.row_slot)
                    report_mismatch($sformatf("row_slot %0d want %0d (win %0d)",
                        o_data.row_slot, want.row_slot, want.window_index));
                if (o_data.fail !== want.fail)
                    report_mismatch($sformatf("fail %0b want %0b (win %0d)",
                        o_data.fail, want.fail, want.window_index));
                if (o_data.end_of_set !== want.end_of_set)
                    report_mismatch($sformatf("end_of_set %0b want %0b (win %0d)",
                        o_data.end_of_set, want.end_of_set, want.window_index));
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Directed: extremes, lone window, zero lower bounds, inverted ranges,
    // no free slot and slot above the upper bound.
    task automatic test_directed();
        send_window('{col_low: 1, col_high: 1, row_low: 1, row_high: 1, last: 1});
        send_window('{col_low: 0, col_high: 127, row_low: 127, row_high: 0, last: 1});
        send_window('{col_low: 2, col_high: 2, row_low: 0, row_high: 1, last: 0});
        send_window('{col_low: 1, col_high: 1, row_low: 1, row_high: 1, last: 0});
        send_window('{col_low: 1, col_high: 3, row_low: 1, row_high: 1, last: 1});
        send_window('{col_low: 3, col_high: 1, row_low: 2, row_high: 2, last: 0});
        send_window('{col_low: 1, col_high: 3, row_low: 1, row_high: 3, last: 0});
        send_window('{col_low: 64, col_high: 64, row_low: 85, row_high: 42, last: 1});
        send_window('{col_low: 1, col_high: 2, row_low: 1, row_high: 2, last: 0});
        send_window('{col_low: 1, col_high: 2, row_low: 1, row_high: 2, last: 1});
        wait_drained();
    endtask

    // Store full: a 64-window set, then extra words dropped, one with last.
    task automatic test_full_store();
        for (int k = 0; k < NWIN + 3; k++)
            send_window(make_window(NWIN, k == NWIN + 2));
        wait_drained();
    endtask

    // Random sets, mostly small, under the given idling rates.
    task automatic test_random(input int sets, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < sets; k++) begin
            send_set($urandom_range(99) < 90 ? $urandom_range(6, 1)
                                             : $urandom_range(20, 7));
            // The sender holds off until everything is back now and then.
            if (k % 7 == 3) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_stall        = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(8, 0, 0);
        test_random(8, 59, 0);
        test_random(8, 0, 59);
        test_random(8, 31, 31);
        test_full_store();
        test_random(2, 0, 0);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_slots.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ window_slot_assigner_core.f @@
src/wsa_pkg.sv
src/wsa_assign_unit.sv
src/window_slot_assigner_core.sv
dv/window_slot_assigner_core_tb.sv
